// ===== hw/rtl/vci_pkg.sv =====
// Shared types and constants for the volume curve interpolator.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package vci_pkg;

  localparam int DATA_W         = 16;
  localparam int INDEX_W        = 4;
  localparam int COUNT_W        = 5;
  localparam int MAX_POINTS_DEF = 16;
  localparam int DIV_STEPS      = 16;  // quotient bits; the quotient is bounded by |v1 - v0|
  localparam int PROD_W         = 2 * (DATA_W + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  // result source
  localparam logic [1:0] SEL_X    = 2'd0;
  localparam logic [1:0] SEL_PV   = 2'd1;
  localparam logic [1:0] SEL_LERP = 2'd2;

  typedef struct packed {
    logic       wr;         // store breakpoint
    logic       load_x;     // capture volume_in
    logic       ld_prev;    // previous point <= read data
    logic       ld_next;    // upper point <= read data
    logic       mul;        // product and divisor
    logic       div_start;
    logic       div_step;
    logic       out_load;
    logic [1:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic key_gt_x;   // read key > x
    logic key_eq_x;   // read key == x
    logic key_ne_pk;  // read key != previous key
  } status_t;

endpackage

// ===== hw/rtl/volume_curve_interpolator.sv =====
// Volume curve interpolator, top level: controller plus datapath.
// Breakpoint write: no result; the next transaction may follow at once.
// Map: with no points in use the input passes through; else a walk of one slot a cycle
// ends on a point or goes on to multiply, divider load and 16 divider steps; out_valid
// rises, once any earlier result is taken, as the block returns to idle for the next one.
// Sync active-high reset clears point count, sequencer and out_valid, not the table.
module volume_curve_interpolator #(
  parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // point_count register
  input  logic                              cfg_wr_en,
  input  logic [vci_pkg::COUNT_W-1:0]       cfg_wr_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [vci_pkg::INDEX_W-1:0]       point_index,
  input  logic signed [vci_pkg::DATA_W-1:0] point_key,
  input  logic signed [vci_pkg::DATA_W-1:0] point_value,
  input  logic signed [vci_pkg::DATA_W-1:0] volume_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vci_pkg::DATA_W-1:0] volume_out
);
  import vci_pkg::*;

  // Controller and datapath talk only through cmd / status and the table
  // read address. A finished result sits in the output register, so the
  // next transaction is accepted while the result waits for out_ready.
  cmd_t                          cmd;
  status_t                       status;
  logic [$clog2(MAX_POINTS)-1:0] rd_addr;

  // Sequencer: point_count (clamped to MAX_POINTS), walk over slots in index
  // order, divider step count, out_valid.
  vci_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .point_index (point_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status)
  );

  // Table RAM, compares, (v1-v0)*(x-k0) multiply, 16-step restoring divide,
  // truncate-toward-zero fixup and the result register.
  vci_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .point_index (point_index),
    .point_key   (point_key),
    .point_value (point_value),
    .volume_in   (volume_in),
    .status      (status),
    .volume_out  (volume_out)
  );

endmodule

// ===== hw/rtl/vci_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/vci_dp.sv =====
// Datapath: breakpoint table, point registers, multiplier, restoring divider
// and the result register. Depends on vci_pkg and vci_ram.
module vci_dp #(
  parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  vci_pkg::cmd_t                       cmd,
  input  logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
  input  logic [vci_pkg::INDEX_W-1:0]         point_index,
  input  logic signed [vci_pkg::DATA_W-1:0]   point_key,
  input  logic signed [vci_pkg::DATA_W-1:0]   point_value,
  input  logic signed [vci_pkg::DATA_W-1:0]   volume_in,
  output vci_pkg::status_t                    status,
  output logic signed [vci_pkg::DATA_W-1:0]   volume_out
);
  import vci_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  logic [2*DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0]   rd_key, rd_val;
  logic signed [DATA_W-1:0]   x, pk, pv, k1, v1;
  logic signed [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]          den;
  logic [DATA_W-1:0]          rem;
  logic [DATA_W-1:0]          quo;
  logic signed [DATA_W:0]     dv, dx, dk;
  logic signed [PROD_W-1:0]   mag;
  logic [DATA_W:0]            trial;
  logic                       fits;
  logic                       rnz;
  logic signed [DATA_W+1:0]   q_ext, q_s, t_s, lerp;
  logic signed [DATA_W-1:0]   res;

  vci_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (AW'(point_index)),
    .wdata ({point_key, point_value}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rd_key = rdata[2*DATA_W-1:DATA_W];
  assign rd_val = rdata[DATA_W-1:0];

  assign status.key_gt_x  = rd_key > x;
  assign status.key_eq_x  = rd_key == x;
  assign status.key_ne_pk = rd_key != pk;

  // differences, one bit wider to stay exact
  assign dv = {v1[DATA_W-1], v1} - {pv[DATA_W-1], pv};
  assign dx = {x[DATA_W-1], x} - {pk[DATA_W-1], pk};
  assign dk = {k1[DATA_W-1], k1} - {pk[DATA_W-1], pk};

  assign mag = prod[PROD_W-1] ? -prod : prod;

  // one restoring step; rem < den so it fits DATA_W bits
  assign trial = {rem, quo[DATA_W-1]};
  assign fits  = trial >= {1'b0, den};

  // trunc toward zero of pv + prod/den
  assign rnz   = |rem;
  assign q_ext = {2'b00, quo};
  assign q_s   = prod[PROD_W-1] ? (-q_ext - {{(DATA_W+1){1'b0}}, rnz}) : q_ext;
  assign t_s   = {{2{pv[DATA_W-1]}}, pv} + q_s;
  assign lerp  = (rnz && t_s[DATA_W+1]) ? t_s + 18'sd1 : t_s;

  always_comb begin
    case (cmd.out_sel)
      SEL_X:    res = x;
      SEL_PV:   res = pv;
      SEL_LERP: res = lerp[DATA_W-1:0];
      default:  res = pv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x <= volume_in;
    end
    if (cmd.ld_prev) begin
      pk <= rd_key;
      pv <= rd_val;
    end
    if (cmd.ld_next) begin
      k1 <= rd_key;
      v1 <= rd_val;
    end
    if (cmd.mul) begin
      prod <= dv * dx;
      den  <= dk[DATA_W-1:0];
    end
    if (cmd.div_start) begin
      rem <= mag[2*DATA_W-1:DATA_W];
      quo <= mag[DATA_W-1:0];
    end else if (cmd.div_step) begin
      rem <= fits ? DATA_W'(trial - {1'b0, den}) : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
    if (cmd.out_load) begin
      volume_out <= res;
    end
  end

endmodule

// ===== hw/rtl/vci_ctrl.sv =====
// Controller: config register, table walk sequencer, divider step count and
// output valid. Depends on vci_pkg.
module vci_ctrl #(
  parameter int MAX_POINTS = vci_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [vci_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [vci_pkg::INDEX_W-1:0]       point_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vci_pkg::cmd_t                     cmd,
  output logic [$clog2(MAX_POINTS)-1:0]     rd_addr,
  input  vci_pkg::status_t                  status
);
  import vci_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW0 = $clog2(MAX_POINTS + 1);
  localparam int CW  = CW0 > COUNT_W ? CW0 : COUNT_W;
  localparam int DW  = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DINIT = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state, state_next;
  logic [COUNT_W-1:0] point_count;
  logic [AW-1:0]      idx, idx_next;
  logic [DW-1:0]      dcnt, dcnt_next;
  logic [1:0]         sel, sel_next;
  logic [CW-1:0]      count_ext, n_used;
  logic               last;
  logic               accept;
  logic               out_free;

  assign count_ext = CW'(point_count);
  assign n_used    = count_ext > CW'(MAX_POINTS) ? CW'(MAX_POINTS) : count_ext;
  assign last      = (CW'(idx) + CW'(1)) == n_used;
  assign in_ready  = state == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign rd_addr   = (state == S_IDLE) ? '0 : AW'(idx + AW'(1));

  always_comb begin
    state_next = state;
    idx_next   = idx;
    dcnt_next  = dcnt;
    sel_next   = sel;
    cmd        = '0;
    cmd.out_sel = sel;
    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          if (command == CMD_WRITE) begin
            cmd.wr = 32'(point_index) < MAX_POINTS;
          end else begin
            cmd.load_x = 1'b1;
            if (n_used == '0) begin
              sel_next   = SEL_X;
              state_next = S_OUT;
            end else begin
              state_next = S_FIRST;
            end
          end
        end
      end
      S_FIRST: begin
        cmd.ld_prev = 1'b1;
        sel_next    = SEL_PV;
        if (status.key_gt_x || status.key_eq_x || last) begin
          state_next = S_OUT;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (status.key_gt_x && status.key_ne_pk) begin
          cmd.ld_next = 1'b1;
          state_next  = S_MUL;
        end else begin
          cmd.ld_prev = 1'b1;
          if (status.key_eq_x || last) begin
            state_next = S_OUT;
          end else begin
            idx_next = idx + AW'(1);
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_start = 1'b1;
        dcnt_next     = '0;
        sel_next      = SEL_LERP;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + DW'(1);
        if (dcnt == DW'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      dcnt        <= '0;
      sel         <= SEL_X;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      dcnt  <= dcnt_next;
      sel   <= sel_next;
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/vci_checker.sv =====
// Port-level checker for the volume curve interpolator, bound to the top level.
// Depends on vci_pkg.
module vci_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [vci_pkg::DATA_W-1:0] volume_out
);
  import vci_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(volume_out))
    else $error("result changed while stalled");

  // accepting a map takes the block out of idle
  a_map_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_MAP |=> !in_ready)
    else $error("ready stayed high after a map transaction");

  // a breakpoint write produces no result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_WRITE && !out_valid |=> !out_valid)
    else $error("result appeared after a breakpoint write");

  // a new result appears only as the block returns to idle
  a_rise_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind volume_curve_interpolator vci_props u_vci_props (.*);

// ===== test/vci_checker.sv =====
// Transaction checker for the volume curve interpolator: watches the config port
// and both channels, predicts each mapped volume and compares it with volume_out.
// Depends on vci_pkg.
module vci_checker import vci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [COUNT_W-1:0]       cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     command,
  input  logic [INDEX_W-1:0]       point_index,
  input  logic signed [DATA_W-1:0] point_key,
  input  logic signed [DATA_W-1:0] point_value,
  input  logic signed [DATA_W-1:0] volume_in,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] volume_out,
  output int                       fail_count,
  output int                       pending,
  output int                       maps_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [COUNT_W-1:0]       curve_len;
  logic signed [DATA_W-1:0] bp_key [MAX_POINTS_DEF];
  logic signed [DATA_W-1:0] bp_val [MAX_POINTS_DEF];
  logic signed [DATA_W-1:0] mapped_q [$];

  task automatic flag_error(input string msg);
    $display("%0t ns: ERROR %s", $realtime, msg);
    fail_count++;
  endtask

  // Exact rational v0 + (v1-v0)*(x-k0)/(k1-k0), truncated toward zero.
  // Folding v0 into the numerator lets the native truncating divide do the rounding.
  function automatic logic signed [DATA_W-1:0] blend(
    input logic signed [DATA_W-1:0] k0, input logic signed [DATA_W-1:0] v0,
    input logic signed [DATA_W-1:0] k1, input logic signed [DATA_W-1:0] v1,
    input logic signed [DATA_W-1:0] x);
    longint span;
    longint num;
    span = longint'(k1) - longint'(k0);
    num  = longint'(v0) * span + (longint'(v1) - longint'(v0)) * (longint'(x) - longint'(k0));
    return DATA_W'(num / span);
  endfunction

  function automatic logic signed [DATA_W-1:0] map_curve(input logic signed [DATA_W-1:0] x);
    int n;
    int i;
    logic signed [DATA_W-1:0] lk;
    logic signed [DATA_W-1:0] lv;
    n = (curve_len > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(curve_len);
    if (n == 0) return x;
    lk = bp_key[0];
    lv = bp_val[0];
    if (x > lk) begin
      // walk in slot order; a repeated key never forms a segment
      for (i = 0; i < n; i++) begin
        if (bp_key[i] > x && bp_key[i] != lk) return blend(lk, lv, bp_key[i], bp_val[i], x);
        lk = bp_key[i];
        lv = bp_val[i];
        if (lk == x) return lv;
      end
    end
    return lv;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      curve_len = '0;
      mapped_q.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) curve_len = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (mapped_q.size() == 0) begin
          flag_error($sformatf("result %0d with no map pending", volume_out));
        end else begin
          if (volume_out !== mapped_q[0])
            flag_error($sformatf("volume_out %0d, predicted %0d", volume_out, mapped_q[0]));
          void'(mapped_q.pop_front());
          maps_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (command == CMD_WRITE) begin
          bp_key[point_index] = point_key;
          bp_val[point_index] = point_value;
        end else begin
          mapped_q = {mapped_q, map_curve(volume_in)};
        end
      end
      pending = mapped_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for volume_curve_interpolator: drives breakpoint writes, map
// transactions and point_count settings; checking is done in vci_checker.
// Depends on vci_pkg, vci_checker and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vci_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 40;   // idle margin after the last result
  localparam int ITEM_TARGET = 470;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]       cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     command = CMD_MAP;
  logic [INDEX_W-1:0]       point_index = '0;
  logic signed [DATA_W-1:0] point_key = '0;
  logic signed [DATA_W-1:0] point_value = '0;
  logic signed [DATA_W-1:0] volume_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] volume_out;

  int fail_count;
  int pending;
  int maps_checked;

  // stimulus bookkeeping
  logic signed [DATA_W-1:0] tbl_key [MAX_POINTS_DEF];  // keys as last written
  int  items_sent;
  int  writes_sent;
  int  count_writes;
  int  burst_left;
  bit  steady;      // no sender gaps in this phase
  int  cycles;

  volume_curve_interpolator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .point_index (point_index),
    .point_key   (point_key),
    .point_value (point_value),
    .volume_in   (volume_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .volume_out  (volume_out)
  );

  vci_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .point_index  (point_index),
    .point_key    (point_key),
    .point_value  (point_value),
    .volume_in    (volume_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .volume_out   (volume_out),
    .fail_count   (fail_count),
    .pending      (pending),
    .maps_checked (maps_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: a lost result or a hung handshake ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("volume_curve_interpolator regression: fail");
      $finish;
    end
  end

  // Result-side back-pressure: modes of random length - always ready, mostly
  // ready, mostly stalled, and a rotating bit pattern.
  int         rx_mode;
  int         rx_left;
  logic [7:0] rx_pat;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
      rx_pat  = 8'($urandom) | 8'h01;
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[7:1]};
      end
    endcase
  end

  // One request transaction. Called at a falling edge, returns at the falling
  // edge after acceptance so the next call may keep valid high without a dip.
  task automatic send_txn(input logic cmd, input logic [INDEX_W-1:0] idx,
                          input logic signed [DATA_W-1:0] k,
                          input logic signed [DATA_W-1:0] v,
                          input logic signed [DATA_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      if (!steady && $urandom_range(0, 15) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    command     <= cmd;
    point_index <= idx;
    point_key   <= k;
    point_value <= v;
    volume_in   <= x;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Unused fields carry random junk; the block must ignore them.
  task automatic write_point(input int idx, input logic signed [DATA_W-1:0] k,
                             input logic signed [DATA_W-1:0] v);
    tbl_key[idx] = k;
    writes_sent++;
    send_txn(CMD_WRITE, INDEX_W'(idx), k, v, DATA_W'($urandom));
  endtask

  task automatic map_vol(input logic signed [DATA_W-1:0] x);
    send_txn(CMD_MAP, INDEX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), x);
  endtask

  // Drop valid and wait until every map has returned, then let the block go
  // quiet; also covers a breakpoint write still in progress.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_count(input int n);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(n);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    count_writes++;
  endtask

  // Load slots 0..n-1. Ordered curves get strictly rising keys, with either
  // tight (1..8) or wide spacing; unordered ones get random keys with repeats.
  task automatic load_curve(input int n, input bit ordered);
    int smax;
    int k;
    int i;
    logic signed [DATA_W-1:0] key;
    if (n == 0) return;
    smax = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 65535 / n;
    k    = -32768 + $urandom_range(0, 65535 - n * smax);
    for (i = 0; i < n; i++) begin
      if (ordered) begin
        key = DATA_W'(k);
        k  += $urandom_range(1, smax);
      end else begin
        key = (i > 0 && $urandom_range(0, 2) == 0) ? tbl_key[i-1] : DATA_W'($urandom);
      end
      write_point(i, key, DATA_W'($urandom));
    end
  endtask

  initial begin
    int phase;
    int cnt;
    int used;
    int nmaps;
    int j;
    int lo;
    int hi;
    logic signed [DATA_W-1:0] x;
    int first_counts [6];

    first_counts = '{16, 1, 2, 31, 0, 17};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed ----
    // no points in use: input passes straight through
    map_vol(16'sh8000);
    map_vol(16'sh7FFF);
    map_vol(16'sh0000);
    // four-point curve spanning both value extremes
    write_point(0, -16'sd30000, 16'sh7FFF);
    write_point(1, -16'sd100,   16'sh8000);
    write_point(2, 16'sd100,    16'sh7FFF);
    write_point(3, 16'sd30000,  16'sh8000);
    set_count(4);
    map_vol(16'sh8000);      // below first key
    map_vol(-16'sd30000);    // equal to first key
    map_vol(-16'sd100);      // equal to an inner key
    map_vol(16'sd0);         // midpoint lands on -0.5, truncates to zero
    map_vol(-16'sd50);
    map_vol(16'sd50);
    map_vol(16'sd29999);
    map_vol(16'sd30000);     // equal to last key
    map_vol(16'sh7FFF);      // above last key
    // repeated key: slot 1 duplicates slot 0 and takes over as the segment start
    write_point(1, -16'sd30000, 16'sd0);
    map_vol(-16'sd30000);
    map_vol(-16'sd20000);

    // ---- random phases ----
    steady = 1'b0;
    load_curve(MAX_POINTS_DEF, 1'b1);  // every slot written before any count > 4
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < 6) cnt = first_counts[phase];
      else if ($urandom_range(0, 9) == 0) cnt = $urandom_range(17, 31);
      else cnt = $urandom_range(0, 16);
      set_count(cnt);
      used   = (cnt > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cnt;
      steady = ($urandom_range(0, 4) == 0);
      load_curve(used, $urandom_range(0, 4) != 0);
      nmaps = $urandom_range(10, 40);
      repeat (nmaps) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray write into any slot, may break key order
          write_point($urandom_range(0, MAX_POINTS_DEF - 1), DATA_W'($urandom),
                      DATA_W'($urandom));
        end else begin
          x = DATA_W'($urandom);
          if (used > 0) begin
            case ($urandom_range(0, 7))
              0: x = DATA_W'($urandom);
              1: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
              2, 3: x = tbl_key[$urandom_range(0, used - 1)];
              4: x = tbl_key[$urandom_range(0, used - 1)] + DATA_W'($urandom_range(0, 6)) - 3;
              default: begin
                // somewhere inside a segment
                j  = (used > 1) ? $urandom_range(0, used - 2) : 0;
                lo = tbl_key[j];
                hi = (used > 1) ? int'(tbl_key[j+1]) : 32767;
                if (hi > lo) x = DATA_W'(lo + $urandom_range(0, hi - lo));
              end
            endcase
          end
          map_vol(x);
        end
      end
      phase++;
    end

    settle();
    $display("covered %0d map results and %0d breakpoint writes over %0d point-count settings",
             maps_checked, writes_sent, count_writes);
    if (fail_count == 0) begin
      $display("volume_curve_interpolator regression: pass");
    end else begin
      $display("volume_curve_interpolator regression: fail");
    end
    $finish;
  end

endmodule

// ===== volume_curve_interpolator.f =====
hw/rtl/vci_pkg.sv
hw/rtl/vci_ram.sv
hw/rtl/vci_dp.sv
hw/rtl/vci_ctrl.sv
hw/rtl/volume_curve_interpolator.sv
hw/rtl/vci_checker.sv
test/vci_checker.sv
test/tb.sv
